/* sv/pwm_lsc_pkg.sv */
// ----------------------------------------------------------------------------
// pwm_lsc_pkg
// Types and constants shared by the PWM LED state classifier modules.
// ----------------------------------------------------------------------------
package pwm_lsc_pkg;

  localparam int unsigned StampW    = 63;
  localparam int unsigned PermilleW = 10;
  localparam int unsigned ProdW     = StampW + PermilleW;
  localparam int unsigned LedW      = 8;
  localparam int unsigned PeriodW   = 32;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PermilleW-1:0] PermilleScale  = 10'd1000;
  localparam logic [LedW-1:0]      LedIdReset     = 8'd0;
  localparam logic [PermilleW-1:0] OnDutyReset    = 10'd950;
  localparam logic [PermilleW-1:0] OffDutyReset   = 10'd50;
  localparam logic [PeriodW-1:0]   MaxPeriodReset = 32'd33333;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLedId     = 2'd0,
    CfgOnDuty    = 2'd1,
    CfgOffDuty   = 2'd2,
    CfgMaxPeriod = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhSecond = 2'd1,
    PhThird  = 2'd2
  } phase_e;

  typedef struct packed {
    logic              pin_level;
    logic [StampW-1:0] stamp_us;
  } in_item_t;

  typedef struct packed {
    logic [LedW-1:0] led_number;
    logic            turn_on;
    logic            last_event;
  } out_item_t;

  typedef struct packed {
    logic              classify;
    logic [StampW-1:0] period;
    logic [StampW-1:0] high;
  } cmd_t;

  typedef struct packed {
    logic [LedW-1:0]      led_id;
    logic [PermilleW-1:0] on_duty_permille;
    logic [PermilleW-1:0] off_duty_permille;
    logic [PeriodW-1:0]   max_steady_period_us;
  } cfg_t;

endpackage

/* sv/pwm_lsc_front.sv */
// ----------------------------------------------------------------------------
// pwm_lsc_front
// Groups pin events into triples and turns each event into a command with
// the measured period and high time.
// ----------------------------------------------------------------------------
module pwm_lsc_front import pwm_lsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_ready_i
);

  phase_e            phase_q, phase_d;
  logic [StampW-1:0] stamp0_q, stamp0_d;
  logic [StampW-1:0] stamp1_q, stamp1_d;
  logic              first_level_q, first_level_d;
  logic              xfer;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign xfer        = in_valid_i && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhFirst;
      stamp0_q      <= '0;
      stamp1_q      <= '0;
      first_level_q <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      stamp0_q      <= stamp0_d;
      stamp1_q      <= stamp1_d;
      first_level_q <= first_level_d;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    stamp0_d       = stamp0_q;
    stamp1_d       = stamp1_q;
    first_level_d  = first_level_q;
    cmd_o.classify = 1'b0;
    cmd_o.period   = in_data_i.stamp_us - stamp0_q;
    cmd_o.high     = first_level_q ? (stamp1_q - stamp0_q) : (in_data_i.stamp_us - stamp1_q);
    case (phase_q)
      PhFirst: begin
        if (xfer) begin
          stamp0_d      = in_data_i.stamp_us;
          first_level_d = in_data_i.pin_level;
          phase_d       = PhSecond;
        end
      end
      PhSecond: begin
        if (xfer) begin
          stamp1_d = in_data_i.stamp_us;
          phase_d  = PhThird;
        end
      end
      default: begin
        cmd_o.classify = 1'b1;
        if (xfer) begin
          phase_d = PhFirst;
        end
      end
    endcase
  end

endmodule

/* sv/pwm_lsc_queue.sv */
// ----------------------------------------------------------------------------
// pwm_lsc_queue
// Small FIFO of commands between the front and the back.
// ----------------------------------------------------------------------------
module pwm_lsc_queue import pwm_lsc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a transfer");

endmodule

/* sv/pwm_lsc_back.sv */
// ----------------------------------------------------------------------------
// pwm_lsc_back
// Duty products, steady/flash decision, LED state and result output.
// ----------------------------------------------------------------------------
module pwm_lsc_back import pwm_lsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_ready_i
);

  // product stage
  logic             m_valid_q, m_valid_d;
  logic             m_classify_q;
  logic             m_zero_q;
  logic             m_fast_q;
  logic [ProdW-1:0] m_high_q;
  logic [ProdW-1:0] m_on_q;
  logic [ProdW-1:0] m_off_q;

  // result stage
  logic [1:0]       rem_q, rem_d;
  logic             on0_q, on0_d;
  logic             on1_q, on1_d;

  logic             lit_q, lit_d;
  logic             blink_q, blink_d;
  logic             slow_q, slow_d;

  logic             out_xfer, res_free, retire, load;
  logic             above, below, cls_emit, cls_on;

  assign out_xfer    = out_valid_o && out_ready_i;
  assign res_free    = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready_i);
  assign retire      = m_valid_q && res_free;
  assign cmd_ready_o = !m_valid_q || retire;
  assign load        = cmd_valid_i && cmd_ready_o;
  assign m_valid_d   = load || (m_valid_q && !retire);

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_classify_q <= cmd_i.classify;
      m_zero_q     <= (cmd_i.period == '0);
      m_fast_q     <= (cmd_i.period <= StampW'(cfg_i.max_steady_period_us));
      m_high_q     <= ProdW'(cmd_i.high) * ProdW'(PermilleScale);
      m_on_q       <= ProdW'(cmd_i.period) * ProdW'(cfg_i.on_duty_permille);
      m_off_q      <= ProdW'(cmd_i.period) * ProdW'(cfg_i.off_duty_permille);
    end
  end

  always_comb begin
    above    = !m_zero_q && (m_high_q > m_on_q);
    below    = !m_zero_q && (m_high_q < m_off_q);
    lit_d    = lit_q;
    blink_d  = blink_q;
    slow_d   = slow_q;
    rem_d    = rem_q;
    on0_d    = on0_q;
    on1_d    = on1_q;
    cls_emit = 1'b0;
    cls_on   = 1'b0;
    if (m_classify_q) begin
      if (above) begin
        cls_emit = !lit_q;
        cls_on   = 1'b1;
      end else if (below) begin
        cls_emit = lit_q;
        cls_on   = 1'b0;
      end else if (m_fast_q) begin
        cls_emit = !lit_q;
        cls_on   = 1'b1;
      end
    end
    if (out_xfer) begin
      rem_d = rem_q - 1'b1;
      on0_d = on1_q;
    end
    if (retire) begin
      if (slow_q) begin
        blink_d = !blink_q;
        on0_d   = blink_q;
        on1_d   = cls_on;
        rem_d   = cls_emit ? 2'd2 : 2'd1;
      end else begin
        on0_d = cls_on;
        rem_d = cls_emit ? 2'd1 : 2'd0;
      end
      if (m_classify_q) begin
        slow_d = !above && !below && !m_fast_q;
        if (cls_emit) begin
          lit_d = cls_on;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      rem_q     <= 2'd0;
      lit_q     <= 1'b0;
      blink_q   <= 1'b0;
      slow_q    <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      rem_q     <= rem_d;
      lit_q     <= lit_d;
      blink_q   <= blink_d;
      slow_q    <= slow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    on0_q <= on0_d;
    on1_q <= on1_d;
  end

  assign out_valid_o           = (rem_q != 2'd0);
  assign out_data_o.led_number = cfg_i.led_id;
  assign out_data_o.turn_on    = on0_q;
  assign out_data_o.last_event = (rem_q == 2'd1);

  assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q != 2'd3)
    else $error("more than two pending results");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && !slow_q && !m_classify_q) |=> (rem_q == 2'd0))
    else $error("result from a non-classifying event outside flash mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && m_classify_q && slow_d) |=> $stable(lit_q))
    else $error("LED state changed on entry to flash mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && !m_classify_q) |=> $stable(slow_q))
    else $error("flash mode changed outside classification");

endmodule

/* sv/pwm_led_state_classifier.sv */
// ----------------------------------------------------------------------------
// pwm_led_state_classifier
// Classifies PWM pin events in triples and drives LED on/off results.
// Path: with the queue empty, an event's first result is offered once it has
// passed the queue, the product stage and the result stage; a second result of
// the same event is offered after the first one transfers.
// Throughput: one event per cycle while the LED side takes every result; an event
// with two results holds the back until its second result has transferred.
// Reset: LED off, flash mode off, triple restarts, registers take defaults.
// ----------------------------------------------------------------------------
module pwm_led_state_classifier import pwm_lsc_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  in_item_t            in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output out_item_t           out_data_o,
  input  logic                out_ready_i
);

  cfg_t cfg_q;
  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_id               <= LedIdReset;
      cfg_q.on_duty_permille     <= OnDutyReset;
      cfg_q.off_duty_permille    <= OffDutyReset;
      cfg_q.max_steady_period_us <= MaxPeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLedId:     cfg_q.led_id               <= cfg_wdata_i[LedW-1:0];
        CfgOnDuty:    cfg_q.on_duty_permille     <= cfg_wdata_i[PermilleW-1:0];
        CfgOffDuty:   cfg_q.off_duty_permille    <= cfg_wdata_i[PermilleW-1:0];
        CfgMaxPeriod: cfg_q.max_steady_period_us <= cfg_wdata_i[PeriodW-1:0];
        default: begin
        end
      endcase
    end
  end

  pwm_lsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  pwm_lsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_cmd),
    .push_ready_o (front_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_cmd),
    .pop_ready_i  (q_ready)
  );

  pwm_lsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

endmodule

/* sim/led_event_checker.sv */
// ----------------------------------------------------------------------------
// led_event_checker
// Watches the event and LED channels and the register port of the PWM LED
// state classifier. Keeps its own copy of the triple tracking, the flash
// toggle and the registers, works out the LED results each accepted pin
// event must cause, and compares every LED result field by field in order.
// ----------------------------------------------------------------------------
module led_event_checker import pwm_lsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  in_item_t            in_data_i,
  input  logic                in_ready_i,
  input  logic                out_valid_i,
  input  out_item_t           out_data_i,
  input  logic                out_ready_i,
  output int unsigned         pending_o,
  output int unsigned         fails_o,
  output int unsigned         results_o
);

  cfg_t              regs;
  logic [StampW-1:0] first_stamp;
  logic [StampW-1:0] second_stamp;
  logic              first_lvl;
  phase_e            ph;
  logic              lit;
  logic              blink;
  logic              flashing;
  out_item_t         led_q[$];
  int unsigned       n_fail;
  int unsigned       n_results;

  task automatic report(input string msg);
    n_fail++;
    $display("[%0t] LED check: %s", $time, msg);
  endtask

  task automatic apply_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (cfg_idx_e'(idx))
      CfgLedId:     regs.led_id               = data[LedW-1:0];
      CfgOnDuty:    regs.on_duty_permille     = data[PermilleW-1:0];
      CfgOffDuty:   regs.off_duty_permille    = data[PermilleW-1:0];
      CfgMaxPeriod: regs.max_steady_period_us = data[PeriodW-1:0];
      default: ;
    endcase
  endtask

  task automatic classify_event(input in_item_t ev);
    out_item_t         res [2];
    int                n;
    logic [StampW-1:0] period;
    logic [StampW-1:0] high;
    logic              above;
    logic              below;
    n     = 0;
    above = 1'b0;
    below = 1'b0;
    if (flashing) begin
      blink  = ~blink;
      res[n] = {regs.led_id, ~blink, 1'b0};
      n++;
    end
    case (ph)
      PhFirst: begin
        first_stamp = ev.stamp_us;
        first_lvl   = ev.pin_level;
        ph          = PhSecond;
      end
      PhSecond: begin
        second_stamp = ev.stamp_us;
        ph           = PhThird;
      end
      default: begin
        period = ev.stamp_us - first_stamp;
        high   = first_lvl ? second_stamp - first_stamp : ev.stamp_us - second_stamp;
        if (period != '0) begin
          above = ProdW'(high) * ProdW'(PermilleScale) >
                  ProdW'(period) * ProdW'(regs.on_duty_permille);
          below = ProdW'(high) * ProdW'(PermilleScale) <
                  ProdW'(period) * ProdW'(regs.off_duty_permille);
        end
        flashing = 1'b0;
        if (above || (!below && period <= StampW'(regs.max_steady_period_us))) begin
          if (!lit) begin
            res[n] = {regs.led_id, 1'b1, 1'b0};
            n++;
            lit = 1'b1;
          end
        end else if (below) begin
          if (lit) begin
            res[n] = {regs.led_id, 1'b0, 1'b0};
            n++;
            lit = 1'b0;
          end
        end else begin
          flashing = 1'b1;
        end
        ph = PhFirst;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        res[i].last_event = 1'b1;
      end
      led_q.push_back(res[i]);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    n_results++;
    if (led_q.size() == 0) begin
      report($sformatf("LED result %h with none expected", got));
      return;
    end
    want = led_q.pop_front();
    if (got.led_number !== want.led_number) begin
      report($sformatf("led_number %h, expected %h", got.led_number, want.led_number));
    end
    if (got.turn_on !== want.turn_on) begin
      report($sformatf("turn_on %b, expected %b", got.turn_on, want.turn_on));
    end
    if (got.last_event !== want.last_event) begin
      report($sformatf("last_event %b, expected %b", got.last_event, want.last_event));
    end
  endtask

  initial begin
    n_fail    = 0;
    n_results = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs         = '{LedIdReset, OnDutyReset, OffDutyReset, MaxPeriodReset};
      first_stamp  = '0;
      second_stamp = '0;
      first_lvl    = 1'b0;
      ph           = PhFirst;
      lit          = 1'b0;
      blink        = 1'b0;
      flashing     = 1'b0;
      led_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        classify_event(in_data_i);
      end
      if (cfg_we_i) begin
        apply_write(cfg_idx_i, cfg_wdata_i);
      end
    end
    pending_o = led_q.size();
    fails_o   = n_fail;
    results_o = n_results;
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the PWM LED state classifier test. Sends a short directed run of
// pin event triples, then random triples under several register settings,
// with random gaps on both channels and long LED-side holds that back the
// block up. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb;
  import pwm_lsc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned TriplesPer = 95;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CfgLedId;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  in_item_t            in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  out_item_t           out_data;
  logic                out_ready = 1'b0;

  int unsigned         pending;
  int unsigned         fails;
  int unsigned         results;
  int unsigned         cycle_cnt = 0;
  int unsigned         sent      = 0;
  logic                send_calm = 1'b0;
  logic [StampW-1:0]   now       = '0;
  cfg_t                cur;

  pwm_led_state_classifier u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_ready)
  );

  led_event_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_ready_i  (in_ready),
    .out_valid_i (out_valid),
    .out_data_i  (out_data),
    .out_ready_i (out_ready),
    .pending_o   (pending),
    .fails_o     (fails),
    .results_o   (results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("pwm_led_state_classifier test failed");
      $finish;
    end
  end

  // LED side: random stalls, calm stretches, and two long holds
  initial begin : led_sink
    int unsigned stall;
    int unsigned got;
    logic        calm;
    got  = 0;
    calm = 1'b0;
    forever begin
      if (got % 64 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      stall = calm ? 0 : $urandom_range(0, 7);
      if (got == 150 || got == 700) begin
        stall = 400;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  task automatic push_event(input logic lvl, input logic [StampW-1:0] stamp);
    int unsigned gap;
    if (sent % 48 == 0) begin
      send_calm = ($urandom_range(0, 3) == 0);
    end
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {lvl, stamp};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic push_triple(input logic lvl, input logic [StampW-1:0] per,
                             input logic [StampW-1:0] hi);
    logic [StampW-1:0] mid;
    mid = lvl ? now + hi : now + per - hi;
    push_event(lvl, now);
    push_event(1'($urandom_range(0, 1)), mid);
    push_event(1'($urandom_range(0, 1)), now + per);
    now = now + per + StampW'($urandom_range(0, 5000));
  endtask

  task automatic random_triple();
    logic [StampW-1:0] per;
    logic [StampW-1:0] hi;
    logic [ProdW-1:0]  knee;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      for (int i = 0; i < 3; i++) begin
        push_event(1'($urandom_range(0, 1)), StampW'({$urandom, $urandom}));
      end
      return;
    end
    if (pick < 15) per = '0;
    else if (pick < 40) per = StampW'($urandom_range(1, 3000));
    else if (pick < 62) per = StampW'(cur.max_steady_period_us) +
                              StampW'($urandom_range(0, 4)) - StampW'(2);
    else if (pick < 88) per = StampW'($urandom_range(1, 1 << 20));
    else per = StampW'({$urandom, $urandom});
    pick = $urandom_range(0, 9);
    case (pick)
      0: hi = '0;
      1: hi = per;
      2, 3: begin
        knee = ProdW'(per) * ProdW'(cur.on_duty_permille) / ProdW'(PermilleScale);
        hi   = StampW'(knee) + StampW'($urandom_range(0, 2)) - StampW'(1);
      end
      4, 5: begin
        knee = ProdW'(per) * ProdW'(cur.off_duty_permille) / ProdW'(PermilleScale);
        hi   = StampW'(knee) + StampW'($urandom_range(0, 2)) - StampW'(1);
      end
      6: hi = StampW'({$urandom, $urandom});
      default: hi = StampW'({$urandom, $urandom} % (64'(per) + 64'd1));
    endcase
    push_triple(1'($urandom_range(0, 1)), per, hi);
  endtask

  // Drop valid, drain the LED results, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgLedId;
    cfg_wdata <= CfgDataW'(c.led_id);
    @(posedge clk);
    cfg_idx   <= CfgOnDuty;
    cfg_wdata <= CfgDataW'(c.on_duty_permille);
    @(posedge clk);
    cfg_idx   <= CfgOffDuty;
    cfg_wdata <= CfgDataW'(c.off_duty_permille);
    @(posedge clk);
    cfg_idx   <= CfgMaxPeriod;
    cfg_wdata <= CfgDataW'(c.max_steady_period_us);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur = c;
  endtask

  initial begin : stimulus
    cfg_t plan [NumPhases];
    plan[0] = '{8'hA5, 10'd950, 10'd50, 32'd33333};
    plan[1] = '{8'hFF, 10'd1000, 10'd0, 32'd0};
    plan[2] = '{8'h00, 10'd0, 10'd1000, 32'hFFFF_FFFF};
    plan[3] = '{8'h5A, 10'd1023, 10'd1023, 32'd5000};
    plan[4].led_id               = LedW'($urandom_range(0, 255));
    plan[4].on_duty_permille     = PermilleW'($urandom_range(0, 1023));
    plan[4].off_duty_permille    = PermilleW'($urandom_range(0, 1023));
    plan[4].max_steady_period_us = PeriodW'($urandom_range(0, 100000));
    plan[5] = '{8'h3C, 10'd700, 10'd300, 32'd2000};
    cur = '{LedIdReset, OnDutyReset, OffDutyReset, MaxPeriodReset};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed triples under the reset settings
    push_triple(1'b1, StampW'(0), StampW'(0));
    push_triple(1'b1, StampW'(1000), StampW'(990));
    push_triple(1'b0, StampW'(1000), StampW'(10));
    push_triple(1'b1, StampW'(1000), StampW'(500));
    push_triple(1'b0, StampW'(100000), StampW'(50000));
    push_triple(1'b1, StampW'(20000), StampW'(100));
    push_triple(1'b0, StampW'(0), StampW'(0));
    now = '1;
    push_triple(1'b1, StampW'(6), StampW'(3));
    now = StampW'(5000);
    push_triple(1'b0, StampW'(0) - StampW'(2000), StampW'(500));

    for (int p = 0; p < NumPhases; p++) begin
      load_regs(plan[p]);
      for (int t = 0; t < TriplesPer; t++) begin
        random_triple();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    $display("covered %0d pin events under %0d register settings", sent, NumPhases + 1);
    $display("checked %0d LED results, %0d left waiting", results, pending);
    if (fails == 0 && pending == 0) begin
      $display("pwm_led_state_classifier test passed");
    end else begin
      $display("pwm_led_state_classifier test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pwm_lsc_pkg.sv
sv/pwm_lsc_front.sv
sv/pwm_lsc_queue.sv
sv/pwm_lsc_back.sv
sv/pwm_led_state_classifier.sv
sim/led_event_checker.sv
sim/tb.sv
